### rtl/core/lifegen_pkg.sv
// Shared types and constants for the life automaton generation block.
// Used by the channel interfaces, the top level and the checker.
// No dependencies.
package lifegen_pkg;

  // Payload widths of the command and result channels
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned ROW_BITS_W = 64;

  // Neighbour count: eight neighbours fit in four bits
  localparam int unsigned NBR_W = 4;
  localparam logic [NBR_W-1:0] SURVIVE_CNT = 4'd2;
  localparam logic [NBR_W-1:0] BIRTH_CNT   = 4'd3;

  // Command codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_ADVANCE = 2'd2
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

### rtl/core/lifegen_if.sv
// Command and result channel interfaces for the life automaton block.
// Depends on lifegen_pkg for payload widths.

interface lifegen_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [lifegen_pkg::ACTION_W-1:0] action;
  logic [lifegen_pkg::ROW_W-1:0]    row;
  logic [lifegen_pkg::COL_W-1:0]    col;
  logic                             cell_value;

  modport source (output valid, action, row, col, cell_value, input ready);
  modport sink   (input valid, action, row, col, cell_value, output ready);
endinterface

interface lifegen_res_if;
  logic                               valid;
  logic                               ready;
  logic [lifegen_pkg::ROW_BITS_W-1:0] row_bits;
  logic                               changed;

  modport source (output valid, row_bits, changed, input ready);
  modport sink   (input valid, row_bits, changed, output ready);
endinterface

### rtl/core/life_automaton_generation.sv
// Game of Life board (B3/S23) held in a row-wide synchronous RAM.
// Depends on lifegen_pkg and the channel interfaces in lifegen_if.sv.
//
// Usage:
//   cmd carries one command per transfer: write a cell, read a row, or
//   advance the board one generation. res returns exactly one transfer per
//   command: the row for a read, the changed flag for an advance, zeros
//   otherwise. One command is in flight at a time; cmd.ready is high only
//   while the sequencer is idle.
//   A write is a read-modify-write of one row. The advance cost is set by
//   the single read port: the sweep fetches one row per cycle into a
//   three-row window and writes the new row back in place two rows
//   behind the fetch.
//   Reset clears the sequencer, the result register and one valid bit per
//   row; rows never written since reset read as all dead, so no clearing
//   pass is needed and commands are taken from the first cycle after reset.
//   A stalled result sits in the output register; the block finishes the
//   current command and waits there before taking the next one.
module life_automaton_generation #(
  parameter int unsigned ROWS = 32,
  parameter int unsigned COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  lifegen_cmd_if.sink          cmd,
  lifegen_res_if.source        res
);

  localparam int unsigned RW  = $clog2(ROWS);
  localparam int unsigned CW  = $clog2(ROWS + 1);
  localparam int unsigned CBW = $clog2(COLS);

  // Sequencer
  lifegen_pkg::state_t state, state_next;

  // Captured command
  logic [lifegen_pkg::ACTION_W-1:0] op;
  logic [RW-1:0]                    op_row;
  logic [CBW-1:0]                   op_col;
  logic                             op_val;
  logic                             op_hit;

  // Sweep state
  logic [CW-1:0]   cnt;
  logic [CW:0]     cnt_inc;
  logic [CW-1:0]   cnt_dec;
  logic            sweep_last;
  logic [COLS-1:0] w_up;
  logic [COLS-1:0] w_mid;
  logic [COLS-1:0] sweep_dn;
  logic [COLS-1:0] gen_row;
  logic            any_chg;

  // Board RAM and per-row valid bits
  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld;
  logic [COLS-1:0] rd_q;
  logic            rd_vld;
  logic [COLS-1:0] rd_row;
  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic            wr_en;
  logic [RW-1:0]   wr_addr;
  logic [COLS-1:0] wr_data;
  logic [COLS-1:0] cell_row;
  logic [COLS-1:0] cell_mask;

  // Output register
  logic                               out_valid;
  logic [lifegen_pkg::ROW_BITS_W-1:0] out_bits;
  logic                               out_chg;
  logic                               out_load;

  // Command decode
  logic          cmd_xfer;
  logic          cmd_row_ok;
  logic          cmd_col_ok;
  logic [RW-1:0] cmd_addr;

  assign cmd_xfer   = cmd.valid && cmd.ready;
  assign cmd_row_ok = 32'(cmd.row) < 32'(ROWS);
  assign cmd_col_ok = 32'(cmd.col) < 32'(COLS);
  assign cmd_addr   = RW'(cmd.row);

  // Row as stored: rows not yet written read as dead
  assign rd_row = rd_vld ? rd_q : '0;

  // Single-cell update for a write
  assign cell_mask = COLS'(1) << op_col;
  assign cell_row  = op_val ? (rd_row | cell_mask) : (rd_row & ~cell_mask);

  // Sweep indexing: data for row cnt arrives, row cnt+1 is fetched,
  // new row cnt-1 is written back
  assign cnt_inc    = {1'b0, cnt} + (CW+1)'(1);
  assign cnt_dec    = cnt - CW'(1);
  assign sweep_last = (cnt == CW'(ROWS));
  assign sweep_dn   = sweep_last ? '0 : rd_row;

  // New generation for the middle row of the window
  always_comb begin
    logic [COLS+1:0]               up_p;
    logic [COLS+1:0]               mid_p;
    logic [COLS+1:0]               dn_p;
    logic [lifegen_pkg::NBR_W-1:0] nbr;
    up_p  = {1'b0, w_up, 1'b0};
    mid_p = {1'b0, w_mid, 1'b0};
    dn_p  = {1'b0, sweep_dn, 1'b0};
    gen_row = '0;
    for (int c = 0; c < COLS; c++) begin
      nbr = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
          + 4'(mid_p[c]) + 4'(mid_p[c+2])
          + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      gen_row[c] = (nbr == lifegen_pkg::BIRTH_CNT) ||
                   (w_mid[c] && (nbr == lifegen_pkg::SURVIVE_CNT));
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lifegen_pkg::ST_IDLE: begin
        if (cmd_xfer) begin
          unique case (cmd.action)
            lifegen_pkg::ACT_WRITE:
              state_next = (cmd_row_ok && cmd_col_ok) ? lifegen_pkg::ST_FETCH
                                                      : lifegen_pkg::ST_DONE;
            lifegen_pkg::ACT_ADVANCE: state_next = lifegen_pkg::ST_SWEEP;
            default:                  state_next = lifegen_pkg::ST_DONE;
          endcase
        end
      end
      lifegen_pkg::ST_FETCH: state_next = lifegen_pkg::ST_DONE;
      lifegen_pkg::ST_SWEEP: begin
        if (sweep_last) state_next = lifegen_pkg::ST_DONE;
      end
      lifegen_pkg::ST_DONE: begin
        if (out_load) state_next = lifegen_pkg::ST_IDLE;
      end
      default: state_next = lifegen_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM controls, handshake, result load
  always_comb begin
    cmd.ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cmd_addr;
    wr_en     = 1'b0;
    wr_addr   = op_row;
    wr_data   = cell_row;
    out_load  = 1'b0;
    unique case (state)
      lifegen_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          unique case (cmd.action)
            lifegen_pkg::ACT_WRITE,
            lifegen_pkg::ACT_READ: rd_en = cmd_row_ok;
            lifegen_pkg::ACT_ADVANCE: begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
            default: rd_en = 1'b0;
          endcase
        end
      end
      lifegen_pkg::ST_FETCH: begin
        wr_en = 1'b1;
      end
      lifegen_pkg::ST_SWEEP: begin
        rd_en   = cnt_inc < (CW+1)'(ROWS);
        rd_addr = cnt_inc[RW-1:0];
        wr_en   = (cnt != '0);
        wr_addr = cnt_dec[RW-1:0];
        wr_data = gen_row;
      end
      lifegen_pkg::ST_DONE: begin
        out_load = !out_valid || res.ready;
      end
      default: cmd.ready = 1'b0;
    endcase
  end

  // Board RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= row_vld[rd_addr];
    end
  end

  // Row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lifegen_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command capture and sweep window
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      op      <= cmd.action;
      op_row  <= cmd_addr;
      op_col  <= CBW'(cmd.col);
      op_val  <= cmd.cell_value;
      op_hit  <= cmd_row_ok;
      cnt     <= '0;
      w_up    <= '0;
      w_mid   <= '0;
      any_chg <= 1'b0;
    end else if (state == lifegen_pkg::ST_SWEEP) begin
      w_up  <= w_mid;
      w_mid <= sweep_dn;
      cnt   <= cnt_inc[CW-1:0];
      if (wr_en) any_chg <= any_chg || (gen_row != w_mid);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bits <= (op == lifegen_pkg::ACT_READ && op_hit)
                  ? lifegen_pkg::ROW_BITS_W'(rd_row) : '0;
      out_chg  <= (op == lifegen_pkg::ACT_ADVANCE) && any_chg;
    end
  end

  assign res.valid    = out_valid;
  assign res.row_bits = out_bits;
  assign res.changed  = out_chg;

endmodule

### rtl/core/lifegen_checker.sv
// Port-level checks for life_automaton_generation, bound to the top level.
// Depends on lifegen_pkg for the result width.
module lifegen_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic [lifegen_pkg::ROW_BITS_W-1:0] row_bits,
  input logic                               changed
);

  // Reset empties the result register
  a_rst_res: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Sequencer is idle and taking commands right after reset
  a_rst_rdy: assert property (@(posedge clk) rst |=> cmd_ready)
    else $error("command channel not ready after reset");

  // One command in flight: a transfer closes the command channel
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("second command taken while one is in flight");

  // A result is a row or a change flag, never both
  a_res_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(changed && (row_bits != '0)))
    else $error("result carries row bits and a change flag");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(row_bits) && $stable(changed))
    else $error("stalled result changed");

endmodule

bind life_automaton_generation lifegen_checker u_lifegen_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .row_bits  (res.row_bits),
  .changed   (res.changed)
);

### tb/tb_life_automaton_generation.sv
// Self-checking testbench for life_automaton_generation: cell writes, row reads and
// generation steps checked against a shadow board kept in the testbench.
// Depends on lifegen_pkg, the channel interfaces in lifegen_if.sv and the RTL top.
`timescale 1ns / 100ps

module tb_life_automaton_generation;

  localparam int unsigned NUM_ROWS = 32;
  localparam int unsigned NUM_COLS = 64;
  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  // Command code with no function: board untouched, zero result
  localparam logic [lifegen_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [lifegen_pkg::ACTION_W-1:0] action;
    logic [lifegen_pkg::ROW_W-1:0]    row;
    logic [lifegen_pkg::COL_W-1:0]    col;
    logic                             cell_value;
  } life_cmd_t;

  typedef struct packed {
    logic [lifegen_pkg::ROW_BITS_W-1:0] row_bits;
    logic                               changed;
  } life_result_t;

  logic clk;
  logic rst;

  lifegen_cmd_if cmd_ch ();
  lifegen_res_if res_ch ();

  life_automaton_generation #(
    .ROWS(NUM_ROWS),
    .COLS(NUM_COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Shadow copy of the board, updated in transfer order
  logic [NUM_COLS-1:0] shadow_board [NUM_ROWS];

  life_cmd_t    queued_cmds [$];
  life_result_t due_results [$];
  int unsigned  queued_total;
  int unsigned  mismatch_count;
  int unsigned  quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One B3/S23 step over the whole shadow board; edges count as dead
  function automatic logic next_generation();
    logic [NUM_COLS-1:0] fresh [NUM_ROWS];
    logic [NUM_COLS-1:0] above;
    logic [NUM_COLS-1:0] below;
    logic [NUM_COLS-1:0] here;
    int   live;
    logic any;
    any = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      above = (r > 0) ? shadow_board[r-1] : '0;
      below = (r < NUM_ROWS - 1) ? shadow_board[r+1] : '0;
      here  = shadow_board[r];
      for (int c = 0; c < NUM_COLS; c++) begin
        live = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          if (c + dc >= 0 && c + dc < NUM_COLS) begin
            live += above[c+dc];
            live += below[c+dc];
            if (dc != 0) live += here[c+dc];
          end
        end
        fresh[r][c] = here[c] ? (live == lifegen_pkg::SURVIVE_CNT ||
                                 live == lifegen_pkg::BIRTH_CNT)
                              : (live == lifegen_pkg::BIRTH_CNT);
      end
      if (fresh[r] != here) any = 1'b1;
    end
    if (any) shadow_board = fresh;
    return any;
  endfunction

  // Applies one command to the shadow board and returns the result it should give
  function automatic life_result_t apply_command(life_cmd_t item);
    life_result_t outcome;
    outcome.row_bits = '0;
    outcome.changed  = 1'b0;
    unique case (item.action)
      lifegen_pkg::ACT_WRITE: begin
        if (item.row < NUM_ROWS && item.col < NUM_COLS)
          shadow_board[item.row][item.col] = item.cell_value;
      end
      lifegen_pkg::ACT_READ: begin
        if (item.row < NUM_ROWS) outcome.row_bits = shadow_board[item.row];
      end
      lifegen_pkg::ACT_ADVANCE: outcome.changed = next_generation();
      default: ;
    endcase
    return outcome;
  endfunction

  task automatic push_cmd(input logic [lifegen_pkg::ACTION_W-1:0] action, input int row,
                          input int col, input logic cell_value);
    life_cmd_t item;
    item.action     = action;
    item.row        = row[lifegen_pkg::ROW_W-1:0];
    item.col        = col[lifegen_pkg::COL_W-1:0];
    item.cell_value = cell_value;
    queued_cmds.push_back(item);
    queued_total++;
  endtask

  task automatic push_write(input int row, input int col, input logic cell_value);
    push_cmd(lifegen_pkg::ACT_WRITE, row, col, cell_value);
  endtask

  task automatic push_read(input int row);
    push_cmd(lifegen_pkg::ACT_READ, row, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_advance();
    push_cmd(lifegen_pkg::ACT_ADVANCE, $urandom_range(0, 31), $urandom_range(0, 63),
             1'($urandom_range(0, 1)));
  endtask

  // A few generations, each followed by reads around the region of interest
  task automatic push_evolution(input int base_row);
    int steps;
    int reads;
    steps = $urandom_range(1, 6);
    for (int s = 0; s < steps; s++) begin
      push_advance();
      reads = $urandom_range(0, 3);
      for (int k = 0; k < reads; k++)
        push_read((base_row + $urandom_range(0, 8) + NUM_ROWS - 1) % NUM_ROWS);
    end
  endtask

  // Gap and stall lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Command driver: takes the next queued command once the previous one has transferred
  always @(posedge clk) begin : drive_cmds
    life_cmd_t   item;
    int unsigned gap_left;
    logic        calm;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      gap_left = 0;
      calm = 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        item.action     = cmd_ch.action;
        item.row        = cmd_ch.row;
        item.col        = cmd_ch.col;
        item.cell_value = cmd_ch.cell_value;
        due_results.push_back(apply_command(item));
        if ($urandom_range(0, 63) == 0) calm = ~calm;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          cmd_ch.valid <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
          item = queued_cmds.pop_front();
          cmd_ch.action     <= item.action;
          cmd_ch.row        <= item.row;
          cmd_ch.col        <= item.col;
          cmd_ch.cell_value <= item.cell_value;
          cmd_ch.valid      <= 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, each transfer checked against the oldest expectation
  always @(posedge clk) begin : check_results
    life_result_t want;
    int unsigned  stall_left;
    logic         calm;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      calm = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", '0, res_ch.row_bits);
        end else begin
          want = due_results.pop_front();
          if (res_ch.row_bits !== want.row_bits)
            report_mismatch("row_bits", want.row_bits, res_ch.row_bits);
          if (res_ch.changed !== want.changed)
            report_mismatch("changed", 64'(want.changed), 64'(res_ch.changed));
        end
        if ($urandom_range(0, 63) == 0) calm = ~calm;
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_stall();
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int roll;
    int base_row;
    int base_col;
    int count;
    rst = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.action     = lifegen_pkg::ACT_WRITE;
    cmd_ch.row        = '0;
    cmd_ch.col        = '0;
    cmd_ch.cell_value = 1'b0;
    res_ch.ready      = 1'b0;
    queued_total   = 0;
    mismatch_count = 0;
    for (int r = 0; r < NUM_ROWS; r++) shadow_board[r] = '0;

    // Directed: empty board is stable
    push_advance();
    push_read(0);
    // Corner cells, read back, then they die alone
    push_write(0, 0, 1'b1);
    push_write(0, 63, 1'b1);
    push_write(31, 0, 1'b1);
    push_write(31, 63, 1'b1);
    push_read(0);
    push_read(31);
    push_advance();
    push_read(0);
    push_advance();
    // Blinker against the right edge: no wrap to column 0
    push_write(0, 63, 1'b1);
    push_write(1, 63, 1'b1);
    push_write(2, 63, 1'b1);
    push_advance();
    push_read(1);
    push_read(0);
    // Unused command code
    push_cmd(ACT_UNUSED, 31, 63, 1'b1);
    push_advance();
    push_read(1);
    // Clearing a live cell
    push_write(1, 63, 1'b0);
    push_read(1);

    // Random: mostly seeded regions left to evolve, some noise
    while (queued_total < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        // Random soup in a small window, often against an edge
        case ($urandom_range(0, 3))
          0: base_row = 0;
          1: base_row = NUM_ROWS - 6;
          default: base_row = $urandom_range(0, NUM_ROWS - 6);
        endcase
        case ($urandom_range(0, 3))
          0: base_col = 0;
          1: base_col = NUM_COLS - 8;
          default: base_col = $urandom_range(0, NUM_COLS - 8);
        endcase
        count = $urandom_range(5, 25);
        for (int k = 0; k < count; k++)
          push_write(base_row + $urandom_range(0, 5), base_col + $urandom_range(0, 7),
                     $urandom_range(0, 4) != 0);
        push_evolution(base_row);
      end else if (roll < 65) begin
        // Glider somewhere on the board
        base_row = $urandom_range(0, NUM_ROWS - 3);
        base_col = $urandom_range(0, NUM_COLS - 3);
        push_write(base_row, base_col + 1, 1'b1);
        push_write(base_row + 1, base_col + 2, 1'b1);
        push_write(base_row + 2, base_col, 1'b1);
        push_write(base_row + 2, base_col + 1, 1'b1);
        push_write(base_row + 2, base_col + 2, 1'b1);
        push_evolution(base_row);
      end else if (roll < 85) begin
        // Noise: any code, any fields
        push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 63),
                 1'($urandom_range(0, 1)));
      end else begin
        // Sweep of row reads
        base_row = $urandom_range(0, NUM_ROWS - 1);
        count = $urandom_range(1, 8);
        for (int k = 0; k < count; k++) push_read((base_row + k) % NUM_ROWS);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain, then let the block settle
    while (queued_cmds.size() != 0 || cmd_ch.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
